>>> design/wnm_pkg.sv
// Package for the wildcard name matcher: shared constants, register indexes
// and the ASCII case-folding helper. No dependencies.
package wnm_pkg;

  localparam int PatSlotsMax       = 16;
  localparam int MaxPatternDefault = 16;
  localparam int LenRegW           = 5;
  localparam int CharW             = 8;
  localparam int CfgDataW          = 64;
  localparam int CfgIndexW         = 2;

  localparam logic [CharW-1:0] CharAny  = 8'h3F;
  localparam logic [CharW-1:0] CharStar = 8'h2A;

  localparam logic [LenRegW-1:0]  PatternLengthReset = 5'd1;
  localparam logic [CfgDataW-1:0] CharsLowReset      = 64'd42;
  localparam logic [CfgDataW-1:0] CharsHighReset     = 64'd0;

  typedef enum logic [CfgIndexW-1:0] {
    RegPatternLength = 2'd0,
    RegCharsLow      = 2'd1,
    RegCharsHigh     = 2'd2,
    RegUnused        = 2'd3
  } cfg_reg_t;

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> design/wnm_cfg.sv
// Configuration registers of the wildcard name matcher: pattern length and
// pattern characters, with the effective length saturated. Uses wnm_pkg.
module wnm_cfg import wnm_pkg::*; #(
  parameter int Slots = PatSlotsMax,
  parameter int LenW  = $clog2(PatSlotsMax + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CfgIndexW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data,
  output logic [LenW-1:0]       eff_len,
  output logic [CharW-1:0]      pat_chars [Slots]
);

  logic [LenRegW-1:0]  pattern_length;
  logic [CfgDataW-1:0] chars_low;
  logic [CfgDataW-1:0] chars_high;
  logic [2*CfgDataW-1:0] chars_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PatternLengthReset;
      chars_low      <= CharsLowReset;
      chars_high     <= CharsHighReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        RegPatternLength: pattern_length <= cfg_data[LenRegW-1:0];
        RegCharsLow:      chars_low      <= cfg_data;
        RegCharsHigh:     chars_high     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign chars_all = {chars_high, chars_low};

  always_comb begin
    if (pattern_length > LenRegW'(Slots)) begin
      eff_len = LenW'(Slots);
    end else begin
      eff_len = pattern_length[LenW-1:0];
    end
  end

  for (genvar i = 0; i < Slots; i++) begin : g_chars
    assign pat_chars[i] = chars_all[i*CharW +: CharW];
  end

endmodule

>>> design/wnm_step.sv
// Next-state logic of the wildcard name matcher: star closure, the per-byte
// position advance and the final match test. Uses wnm_pkg.
module wnm_step import wnm_pkg::*; #(
  parameter int Slots = PatSlotsMax,
  parameter int LenW  = $clog2(PatSlotsMax + 1)
) (
  input  logic [Slots:0]   live,
  input  logic [CharW-1:0] text_char,
  input  logic [LenW-1:0]  eff_len,
  input  logic [CharW-1:0] pat_chars [Slots],
  output logic [Slots:0]   live_next,
  output logic             matched
);

  logic [Slots-1:0] star_use;
  logic [Slots-1:0] hit_use;
  logic [Slots:0]   cur;
  logic [Slots:0]   fin;
  logic [CharW-1:0] text_folded;

  // A position j is live after closure when some live k <= j is followed by
  // an unbroken run of in-use stars from k up to j-1.
  function automatic logic [Slots:0] close_stars(input logic [Slots:0] v,
                                                 input logic [Slots-1:0] s);
    logic [Slots:0] r;
    logic           run;
    r = '0;
    for (int j = 0; j <= Slots; j++) begin
      for (int k = 0; k <= j; k++) begin
        run = v[k];
        for (int m = k; m < j; m++) begin
          run = run & s[m];
        end
        r[j] = r[j] | run;
      end
    end
    return r;
  endfunction

  assign text_folded = fold_case(text_char);

  for (genvar i = 0; i < Slots; i++) begin : g_pos
    logic in_use;
    logic is_star;
    assign in_use     = LenW'(i) < eff_len;
    assign is_star    = pat_chars[i] == CharStar;
    assign star_use[i] = in_use & is_star;
    assign hit_use[i]  = in_use & !is_star &
                         ((pat_chars[i] == CharAny) || (fold_case(pat_chars[i]) == text_folded));
  end

  assign cur = close_stars(live, star_use);

  always_comb begin
    live_next = '0;
    for (int i = 0; i < Slots; i++) begin
      live_next[i]   = live_next[i] | (cur[i] & star_use[i]);
      live_next[i+1] = cur[i] & hit_use[i];
    end
  end

  assign fin     = close_stars(live_next, star_use);
  assign matched = fin[eff_len];

endmodule

>>> design/wildcard_name_matcher_core.sv
// Wildcard name matcher top level: input register, position update and
// result register. Uses wnm_pkg, wnm_cfg and wnm_step.
// A name's last byte passes the input register, then the result register.
// Throughput: one byte per cycle, set by the live-position vector update;
// a last byte stalls while a result waits. Reset (synchronous) loads the
// default pattern "*" of length 1, clears both stages, sets live vector to 1.
module wildcard_name_matcher_core import wnm_pkg::*; #(
  parameter int MaxPattern = MaxPatternDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] text_char
  input  logic                 s_axis_tlast,   // last_of_name
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [0] matched, [7:1] zero
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  localparam int Slots = (MaxPattern < PatSlotsMax) ? MaxPattern : PatSlotsMax;
  localparam int LenW  = $clog2(Slots + 1);

  logic [LenW-1:0]  eff_len;
  logic [CharW-1:0] pat_chars [Slots];

  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             in_last;
  logic [Slots:0]   live;
  logic [Slots:0]   live_next;
  logic             step_matched;
  logic             out_valid;
  logic             out_matched;
  logic             out_free;
  logic             in_go;

  wnm_cfg #(.Slots(Slots), .LenW(LenW)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff_len   (eff_len),
    .pat_chars (pat_chars)
  );

  wnm_step #(.Slots(Slots), .LenW(LenW)) u_step (
    .live      (live),
    .text_char (in_char),
    .eff_len   (eff_len),
    .pat_chars (pat_chars),
    .live_next (live_next),
    .matched   (step_matched)
  );

  assign out_free      = !out_valid || m_axis_tready;
  assign in_go         = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || in_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= (Slots + 1)'(1);
    end else if (in_go) begin
      live <= in_last ? (Slots + 1)'(1) : live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_go && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_last) begin
      out_matched <= step_matched;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_matched};

endmodule
